// ===== rtl/rpte_pkg.sv =====
// Shared constants, codes and types for the ranging peer table engine.
// No dependencies; every RTL file imports this package.
`default_nettype none
package rpte_pkg;

    localparam int MAX_PEERS = 8;
    localparam int OWNERS    = MAX_PEERS + 1;
    localparam int SLOTS     = OWNERS * MAX_PEERS;
    localparam int PEER_W    = $clog2(MAX_PEERS);
    localparam int CNT_W     = $clog2(MAX_PEERS + 1);
    localparam int OWN_W     = $clog2(OWNERS);
    localparam int ADDR_W    = $clog2(SLOTS);

    localparam int ID_W      = 16;
    localparam int CERT_W    = 8;
    localparam int FUNC_W    = 4;
    localparam int STAT_W    = 2;
    localparam int ACT_W     = 4;
    localparam int LFSR_W    = 16;
    localparam int DIV_CNT_W = $clog2(LFSR_W);
    localparam int CFG_IDX_W = 2;

    localparam int IN_TDATA_W  = 56;
    localparam int OUT_TDATA_W = 24;

    localparam logic [ID_W-1:0]   DIST_INVALID = 16'hFFFF;
    localparam logic [ID_W-1:0]   PRIO_RESET   = 16'hA262;
    localparam logic [LFSR_W-1:0] SEED_RESET   = 16'h0001;
    localparam logic [LFSR_W-1:0] LFSR_TAPS    = 16'hB400;
    localparam logic [CERT_W-1:0] CERT_MAX     = 8'hFF;

    localparam logic [FUNC_W-1:0] FN_ADD       = 4'd0;
    localparam logic [FUNC_W-1:0] FN_REMOVE    = 4'd1;
    localparam logic [FUNC_W-1:0] FN_SETDIST   = 4'd2;
    localparam logic [FUNC_W-1:0] FN_GETDIST   = 4'd3;
    localparam logic [FUNC_W-1:0] FN_SETCERT   = 4'd4;
    localparam logic [FUNC_W-1:0] FN_BUMP      = 4'd5;
    localparam logic [FUNC_W-1:0] FN_RESETCERT = 4'd6;
    localparam logic [FUNC_W-1:0] FN_GETCERT   = 4'd7;
    localparam logic [FUNC_W-1:0] FN_NEWROUND  = 4'd8;
    localparam logic [FUNC_W-1:0] FN_SELECT    = 4'd9;

    localparam logic [STAT_W-1:0] ST_DONE    = 2'd0;
    localparam logic [STAT_W-1:0] ST_IGNORED = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL    = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_OWN_ID  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PRIO_ID = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SEED    = 2'd2;

    typedef struct packed {
        logic [ID_W-1:0]   pid;
        logic [ID_W-1:0]   distance;
        logic [CERT_W-1:0] cert;
    } slot_t;

    typedef struct packed {
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        slot_t             wr_data;
        logic              clr_en;
        logic [OWN_W-1:0]  clr_owner;
    } ram_req_t;

    typedef struct packed {
        logic              add;
        logic [ID_W-1:0]   add_id;
        logic              del;
        logic [PEER_W-1:0] del_idx;
    } plist_cmd_t;

    typedef struct packed {
        logic [CNT_W-1:0]  cnt;
        logic              a_hit;
        logic [PEER_W-1:0] a_idx;
        logic              b_hit;
        logic [ID_W-1:0]   rd_id;
    } plist_stat_t;

    function automatic logic [ADDR_W-1:0] slot_addr(input logic [OWN_W-1:0] owner,
                                                   input logic [PEER_W-1:0] j);
        return ADDR_W'(int'(owner) * MAX_PEERS + int'(j));
    endfunction

endpackage
`default_nettype wire

// ===== rtl/ranging_peer_table_engine.sv =====
// Top level: request sequencer around the record store and the peer list.
// Depends on rpte_pkg, rpte_slot_ram and rpte_peer_list.
//
//  channel  direction  payload (low bit up)
//  s_*      in         func[3:0] first_id[19:4] second_id[35:20] data_value[51:36]
//  m_*      out        result_value[15:0] status[17:16] active_count[21:18]
//  cfg_*    in         cfg_index 0 own id, 1 priority id, 2 tie seed; cfg_data
//
// One request at a time. Add and unknown codes go straight to the reply; record ops
// scan one full row through the registered read port, and the set ops then write back.
// Remove and new round scan (active+1) rows; remove adds one more row copy unless
// the removed peer was the last. Select loads self's row, then steps through the peers,
// with a bit-serial remainder for each certainty tie. Reset is synchronous and clears all
// records through valid bits at once. A held result stalls only the next request.
`default_nettype none
module ranging_peer_table_engine import rpte_pkg::*; (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [IN_TDATA_W-1:0]  s_tdata,   // func, first_id, second_id, data_value
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [OUT_TDATA_W-1:0]      m_tdata,   // result_value, status, active_count
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [ID_W-1:0]        cfg_data
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_DECODE   = 4'd1;
    localparam logic [3:0] S_RM_SCAN  = 4'd2;
    localparam logic [3:0] S_CP_SCAN  = 4'd3;
    localparam logic [3:0] S_RM_END   = 4'd4;
    localparam logic [3:0] S_NR_SCAN  = 4'd5;
    localparam logic [3:0] S_PW_SCAN  = 4'd6;
    localparam logic [3:0] S_PW_ACT   = 4'd7;
    localparam logic [3:0] S_SEL_LOAD = 4'd8;
    localparam logic [3:0] S_SEL_PEER = 4'd9;
    localparam logic [3:0] S_SEL_DIV  = 4'd10;
    localparam logic [3:0] S_FINISH   = 4'd11;

    logic [3:0]        state_reg, state_next;
    logic [FUNC_W-1:0] func_reg, func_next;
    logic [ID_W-1:0]   a_reg, a_next, b_reg, b_next, data_reg, data_next;
    logic [ID_W-1:0]   own_id_reg, own_id_next, prio_id_reg, prio_id_next;
    logic [LFSR_W-1:0] lfsr_reg, lfsr_next;
    logic [ID_W-1:0]   res_reg, res_next;
    logic [STAT_W-1:0] st_reg, st_next;
    logic [OWN_W-1:0]  owner_reg, owner_next, dst_owner_reg, dst_owner_next;
    logic [PEER_W-1:0] del_idx_reg, del_idx_next;
    logic [CNT_W-1:0]  issue_reg, issue_next;
    logic              rsp_vld_reg, rsp_vld_next;
    logic [PEER_W-1:0] rsp_j_reg, rsp_j_next;
    logic              found_reg, found_next, free_reg, free_next;
    logic [PEER_W-1:0] found_j_reg, found_j_next, free_j_reg, free_j_next;
    slot_t             found_e_reg, found_e_next;
    logic [ID_W-1:0]   cache_pid_reg [MAX_PEERS];
    logic [ID_W-1:0]   cache_pid_next [MAX_PEERS];
    logic [CERT_W-1:0] cache_cert_reg [MAX_PEERS];
    logic [CERT_W-1:0] cache_cert_next [MAX_PEERS];
    logic [CNT_W-1:0]  sel_i_reg, sel_i_next;
    logic [CERT_W:0]   lowest_reg, lowest_next;
    logic [ID_W-1:0]   target_reg, target_next, sel_pid_reg, sel_pid_next;
    logic [CNT_W-1:0]  ties_reg, ties_next, rem_reg, rem_next;
    logic [LFSR_W-1:0] div_val_reg, div_val_next;
    logic [DIV_CNT_W-1:0] div_cnt_reg, div_cnt_next;
    logic              m_valid_reg, m_valid_next;
    logic [ID_W-1:0]   m_res_reg, m_res_next;
    logic [STAT_W-1:0] m_st_reg, m_st_next;
    logic [ACT_W-1:0]  m_cnt_reg, m_cnt_next;

    ram_req_t    ram_req;
    slot_t       rd_e;
    plist_cmd_t  pl_cmd;
    plist_stat_t pl;

    logic [CNT_W-1:0]  cnt_m1;
    logic              rsp_last, issue_more;
    logic              oa_ok, ob_ok;
    logic [OWN_W-1:0]  oa;
    logic [LFSR_W-1:0] lfsr_step;
    logic              c_hit;
    logic [CERT_W-1:0] c_cert;
    logic [CNT_W:0]    div_try;
    slot_t             act_e;

    rpte_slot_ram u_ram (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (ram_req),
        .rd_data (rd_e)
    );

    rpte_peer_list u_plist (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (pl_cmd),
        .a_id    (a_reg),
        .b_id    (b_reg),
        .rd_idx  (sel_i_reg[PEER_W-1:0]),
        .stat    (pl)
    );

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = {2'b00, m_cnt_reg, m_st_reg, m_res_reg};

    assign cnt_m1     = pl.cnt - CNT_W'(1);
    assign rsp_last   = rsp_vld_reg && (rsp_j_reg == PEER_W'(MAX_PEERS - 1));
    assign issue_more = issue_reg < CNT_W'(MAX_PEERS);
    assign oa_ok      = (a_reg == own_id_reg) || pl.a_hit;
    assign ob_ok      = (b_reg == own_id_reg) || pl.b_hit;
    assign oa         = (a_reg == own_id_reg) ? '0 : OWN_W'(pl.a_idx) + OWN_W'(1);
    assign lfsr_step  = lfsr_reg[0] ? ((lfsr_reg >> 1) ^ LFSR_TAPS) : (lfsr_reg >> 1);
    assign div_try    = {rem_reg, div_val_reg[LFSR_W-1]};

    always_comb begin
        c_hit  = 1'b0;
        c_cert = '0;
        for (int k = 0; k < MAX_PEERS; k++) begin
            if (cache_pid_reg[k] == pl.rd_id) begin
                c_hit  = 1'b1;
                c_cert = cache_cert_reg[k];
            end
        end
    end

    always_comb begin
        state_next     = state_reg;
        func_next      = func_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        data_next      = data_reg;
        own_id_next    = own_id_reg;
        prio_id_next   = prio_id_reg;
        lfsr_next      = lfsr_reg;
        res_next       = res_reg;
        st_next        = st_reg;
        owner_next     = owner_reg;
        dst_owner_next = dst_owner_reg;
        del_idx_next   = del_idx_reg;
        issue_next     = issue_reg;
        rsp_vld_next   = 1'b0;
        rsp_j_next     = rsp_j_reg;
        found_next     = found_reg;
        found_j_next   = found_j_reg;
        found_e_next   = found_e_reg;
        free_next      = free_reg;
        free_j_next    = free_j_reg;
        cache_pid_next  = cache_pid_reg;
        cache_cert_next = cache_cert_reg;
        sel_i_next     = sel_i_reg;
        lowest_next    = lowest_reg;
        target_next    = target_reg;
        sel_pid_next   = sel_pid_reg;
        ties_next      = ties_reg;
        rem_next       = rem_reg;
        div_val_next   = div_val_reg;
        div_cnt_next   = div_cnt_reg;
        m_valid_next   = m_valid_reg && !m_tready;
        m_res_next     = m_res_reg;
        m_st_next      = m_st_reg;
        m_cnt_next     = m_cnt_reg;
        ram_req        = '0;
        pl_cmd         = '0;
        act_e          = found_e_reg;

        if (cfg_valid) begin
            unique case (cfg_index)
                CFG_OWN_ID:  own_id_next  = cfg_data;
                CFG_PRIO_ID: prio_id_next = cfg_data;
                CFG_SEED:    lfsr_next    = (cfg_data != '0) ? cfg_data : SEED_RESET;
                default: ;
            endcase
        end

        // shared row scan: one read per cycle, data back in the next cycle
        if ((state_reg == S_RM_SCAN || state_reg == S_CP_SCAN || state_reg == S_NR_SCAN ||
             state_reg == S_PW_SCAN || state_reg == S_SEL_LOAD) && issue_more) begin
            ram_req.rd_en   = 1'b1;
            ram_req.rd_addr = slot_addr(owner_reg, issue_reg[PEER_W-1:0]);
            issue_next      = issue_reg + CNT_W'(1);
            rsp_vld_next    = 1'b1;
            rsp_j_next      = issue_reg[PEER_W-1:0];
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    func_next  = s_tdata[3:0];
                    a_next     = s_tdata[19:4];
                    b_next     = s_tdata[35:20];
                    data_next  = s_tdata[51:36];
                    state_next = S_DECODE;
                end
            end

            S_DECODE: begin
                res_next   = '0;
                st_next    = ST_IGNORED;
                found_next = 1'b0;
                free_next  = 1'b0;
                issue_next = '0;
                owner_next = '0;
                state_next = S_FINISH;
                unique case (func_reg)
                    FN_ADD: begin
                        if (a_reg != '0 && !pl.a_hit) begin
                            if (pl.cnt >= CNT_W'(MAX_PEERS)) begin
                                st_next = ST_FULL;
                            end else begin
                                ram_req.clr_en    = 1'b1;
                                ram_req.clr_owner = OWN_W'(pl.cnt) + OWN_W'(1);
                                pl_cmd.add        = 1'b1;
                                pl_cmd.add_id     = a_reg;
                                st_next           = ST_DONE;
                            end
                        end
                    end
                    FN_REMOVE: begin
                        if (pl.a_hit) begin
                            del_idx_next = pl.a_idx;
                            st_next      = ST_DONE;
                            state_next   = S_RM_SCAN;
                        end
                    end
                    FN_SETDIST, FN_GETDIST, FN_SETCERT, FN_BUMP, FN_RESETCERT,
                    FN_GETCERT: begin
                        if (func_reg == FN_GETDIST) begin
                            res_next = DIST_INVALID;
                        end
                        if (oa_ok && ob_ok && b_reg != '0) begin
                            owner_next = oa;
                            state_next = S_PW_SCAN;
                        end
                    end
                    FN_NEWROUND: begin
                        st_next    = ST_DONE;
                        state_next = S_NR_SCAN;
                    end
                    FN_SELECT: begin
                        state_next = S_SEL_LOAD;
                    end
                    default: ;
                endcase
            end

            S_RM_SCAN: begin
                if (rsp_vld_reg && rd_e.pid == a_reg) begin
                    ram_req.wr_en   = 1'b1;
                    ram_req.wr_addr = slot_addr(owner_reg, rsp_j_reg);
                    ram_req.wr_data = '{pid: rd_e.pid, distance: DIST_INVALID, cert: '0};
                end
                if (rsp_last) begin
                    issue_next = '0;
                    if (owner_reg < OWN_W'(pl.cnt)) begin
                        owner_next = owner_reg + OWN_W'(1);
                    end else if (del_idx_reg != cnt_m1[PEER_W-1:0]) begin
                        owner_next     = OWN_W'(pl.cnt);
                        dst_owner_next = OWN_W'(del_idx_reg) + OWN_W'(1);
                        state_next     = S_CP_SCAN;
                    end else begin
                        state_next = S_RM_END;
                    end
                end
            end

            S_CP_SCAN: begin
                // last owner's row moves into the removed peer's row
                if (rsp_vld_reg) begin
                    ram_req.wr_en   = 1'b1;
                    ram_req.wr_addr = slot_addr(dst_owner_reg, rsp_j_reg);
                    ram_req.wr_data = rd_e;
                end
                if (rsp_last) begin
                    state_next = S_RM_END;
                end
            end

            S_RM_END: begin
                ram_req.clr_en    = 1'b1;
                ram_req.clr_owner = OWN_W'(pl.cnt);
                pl_cmd.del        = 1'b1;
                pl_cmd.del_idx    = del_idx_reg;
                state_next        = S_FINISH;
            end

            S_NR_SCAN: begin
                if (rsp_vld_reg && rd_e.pid != '0) begin
                    ram_req.wr_en   = 1'b1;
                    ram_req.wr_addr = slot_addr(owner_reg, rsp_j_reg);
                    ram_req.wr_data = '{pid: rd_e.pid, distance: DIST_INVALID, cert: rd_e.cert};
                end
                if (rsp_last) begin
                    issue_next = '0;
                    if (owner_reg < OWN_W'(pl.cnt)) begin
                        owner_next = owner_reg + OWN_W'(1);
                    end else begin
                        state_next = S_FINISH;
                    end
                end
            end

            S_PW_SCAN: begin
                if (rsp_vld_reg) begin
                    if (!found_reg && rd_e.pid == b_reg) begin
                        found_next   = 1'b1;
                        found_j_next = rsp_j_reg;
                        found_e_next = rd_e;
                    end
                    if (!free_reg && rd_e.pid == '0) begin
                        free_next   = 1'b1;
                        free_j_next = rsp_j_reg;
                    end
                end
                if (rsp_last) begin
                    state_next = S_PW_ACT;
                end
            end

            S_PW_ACT: begin
                state_next      = S_FINISH;
                ram_req.wr_addr = slot_addr(owner_reg, found_reg ? found_j_reg : free_j_reg);
                if (!found_reg) begin
                    act_e = '{pid: b_reg, distance: DIST_INVALID, cert: '0};
                end
                unique case (func_reg)
                    FN_SETDIST, FN_SETCERT, FN_BUMP: begin
                        if (!found_reg && !free_reg) begin
                            st_next = ST_FULL;
                        end else begin
                            if (func_reg == FN_SETDIST) begin
                                act_e.distance = data_reg;
                            end else if (func_reg == FN_SETCERT) begin
                                act_e.cert = data_reg[CERT_W-1:0];
                            end else if (act_e.cert != CERT_MAX) begin
                                act_e.cert = act_e.cert + CERT_W'(1);
                            end
                            ram_req.wr_en   = 1'b1;
                            ram_req.wr_data = act_e;
                            st_next         = ST_DONE;
                        end
                    end
                    FN_GETDIST: begin
                        if (found_reg) begin
                            res_next = found_e_reg.distance;
                            st_next  = ST_DONE;
                        end
                    end
                    FN_RESETCERT: begin
                        if (found_reg) begin
                            act_e.cert      = '0;
                            ram_req.wr_en   = 1'b1;
                            ram_req.wr_data = act_e;
                            st_next         = ST_DONE;
                        end
                    end
                    FN_GETCERT: begin
                        if (found_reg && found_e_reg.distance != DIST_INVALID) begin
                            res_next = ID_W'(found_e_reg.cert);
                            st_next  = ST_DONE;
                        end
                    end
                    default: ;
                endcase
            end

            S_SEL_LOAD: begin
                if (rsp_vld_reg) begin
                    cache_pid_next[rsp_j_reg]  = rd_e.pid;
                    cache_cert_next[rsp_j_reg] = rd_e.cert;
                end
                if (rsp_last) begin
                    sel_i_next  = '0;
                    lowest_next = (CERT_W + 1)'(256);
                    target_next = '0;
                    ties_next   = '0;
                    state_next  = S_SEL_PEER;
                end
            end

            S_SEL_PEER: begin
                sel_i_next = sel_i_reg + CNT_W'(1);
                if (sel_i_reg >= pl.cnt) begin
                    sel_i_next = sel_i_reg;
                    res_next   = target_reg;
                    st_next    = (target_reg != '0) ? ST_DONE : ST_IGNORED;
                    state_next = S_FINISH;
                end else if (pl.rd_id == own_id_reg) begin
                    // self in the list is never a target
                end else if ((own_id_reg != prio_id_reg && pl.rd_id == prio_id_reg) ||
                             !c_hit) begin
                    res_next   = pl.rd_id;
                    st_next    = ST_DONE;
                    state_next = S_FINISH;
                end else if ({1'b0, c_cert} < lowest_reg) begin
                    lowest_next = {1'b0, c_cert};
                    target_next = pl.rd_id;
                    ties_next   = CNT_W'(1);
                end else if ({1'b0, c_cert} == lowest_reg) begin
                    // tie: draw new LFSR value, take this peer if value mod ties is zero
                    sel_i_next   = sel_i_reg;
                    ties_next    = ties_reg + CNT_W'(1);
                    lfsr_next    = lfsr_step;
                    div_val_next = lfsr_step;
                    div_cnt_next = '0;
                    rem_next     = '0;
                    sel_pid_next = pl.rd_id;
                    state_next   = S_SEL_DIV;
                end
            end

            S_SEL_DIV: begin
                if (div_try >= (CNT_W + 1)'(ties_reg)) begin
                    rem_next = CNT_W'(div_try - (CNT_W + 1)'(ties_reg));
                end else begin
                    rem_next = div_try[CNT_W-1:0];
                end
                div_val_next = div_val_reg << 1;
                div_cnt_next = div_cnt_reg + DIV_CNT_W'(1);
                if (div_cnt_reg == DIV_CNT_W'(LFSR_W - 1)) begin
                    if (rem_next == '0) begin
                        target_next = sel_pid_reg;
                    end
                    sel_i_next = sel_i_reg + CNT_W'(1);
                    state_next = S_SEL_PEER;
                end
            end

            S_FINISH: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_res_next   = res_reg;
                    m_st_next    = st_reg;
                    m_cnt_next   = ACT_W'(pl.cnt);
                    state_next   = S_IDLE;
                end
            end

            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            own_id_reg  <= '0;
            prio_id_reg <= PRIO_RESET;
            lfsr_reg    <= SEED_RESET;
            rsp_vld_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            own_id_reg  <= own_id_next;
            prio_id_reg <= prio_id_next;
            lfsr_reg    <= lfsr_next;
            rsp_vld_reg <= rsp_vld_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        func_reg      <= func_next;
        a_reg         <= a_next;
        b_reg         <= b_next;
        data_reg      <= data_next;
        res_reg       <= res_next;
        st_reg        <= st_next;
        owner_reg     <= owner_next;
        dst_owner_reg <= dst_owner_next;
        del_idx_reg   <= del_idx_next;
        issue_reg     <= issue_next;
        rsp_j_reg     <= rsp_j_next;
        found_reg     <= found_next;
        found_j_reg   <= found_j_next;
        found_e_reg   <= found_e_next;
        free_reg      <= free_next;
        free_j_reg    <= free_j_next;
        cache_pid_reg  <= cache_pid_next;
        cache_cert_reg <= cache_cert_next;
        sel_i_reg     <= sel_i_next;
        lowest_reg    <= lowest_next;
        target_reg    <= target_next;
        sel_pid_reg   <= sel_pid_next;
        ties_reg      <= ties_next;
        rem_reg       <= rem_next;
        div_val_reg   <= div_val_next;
        div_cnt_reg   <= div_cnt_next;
        m_res_reg     <= m_res_next;
        m_st_reg      <= m_st_next;
        m_cnt_reg     <= m_cnt_next;
    end

endmodule
`default_nettype wire

// ===== rtl/rpte_slot_ram.sv =====
// Pairwise record store: one row of MAX_PEERS records per owner.
// Synchronous (registered) read, one write port, per-entry valid bits. Uses rpte_pkg.
`default_nettype none
module rpte_slot_ram import rpte_pkg::*; (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire ram_req_t req,
    output slot_t         rd_data
);

    slot_t             mem [SLOTS];
    logic [SLOTS-1:0]  valid_reg;
    slot_t             rd_q_reg;
    logic              rd_vld_reg;

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en) begin
            rd_q_reg <= mem[req.rd_addr];
        end
    end

    // invalid entries read as an all-zero (free) record
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg  <= '0;
            rd_vld_reg <= 1'b0;
        end else begin
            if (req.wr_en) begin
                valid_reg[req.wr_addr] <= 1'b1;
            end
            if (req.clr_en) begin
                for (int j = 0; j < MAX_PEERS; j++) begin
                    valid_reg[slot_addr(req.clr_owner, PEER_W'(j))] <= 1'b0;
                end
            end
            if (req.rd_en) begin
                rd_vld_reg <= valid_reg[req.rd_addr];
            end
        end
    end

    assign rd_data = rd_vld_reg ? rd_q_reg : '0;

endmodule
`default_nettype wire

// ===== rtl/rpte_peer_list.sv =====
// Packed list of active peer IDs with parallel ID lookup.
// Append and swap-with-last removal. Uses rpte_pkg.
`default_nettype none
module rpte_peer_list import rpte_pkg::*; (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire plist_cmd_t        cmd,
    input  wire logic [ID_W-1:0]   a_id,
    input  wire logic [ID_W-1:0]   b_id,
    input  wire logic [PEER_W-1:0] rd_idx,
    output plist_stat_t            stat
);

    logic [ID_W-1:0]  ids_reg [MAX_PEERS];
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_m1;

    assign cnt_m1 = cnt_reg - CNT_W'(1);

    always_comb begin
        stat       = '0;
        stat.cnt   = cnt_reg;
        stat.rd_id = ids_reg[rd_idx];
        // downward so the lowest matching index wins
        for (int i = MAX_PEERS - 1; i >= 0; i--) begin
            if (i < int'(cnt_reg) && ids_reg[i] == a_id) begin
                stat.a_hit = 1'b1;
                stat.a_idx = PEER_W'(i);
            end
            if (i < int'(cnt_reg) && ids_reg[i] == b_id) begin
                stat.b_hit = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
            for (int i = 0; i < MAX_PEERS; i++) begin
                ids_reg[i] <= '0;
            end
        end else if (cmd.add) begin
            ids_reg[cnt_reg[PEER_W-1:0]] <= cmd.add_id;
            cnt_reg                      <= cnt_reg + CNT_W'(1);
        end else if (cmd.del) begin
            if (cmd.del_idx != cnt_m1[PEER_W-1:0]) begin
                ids_reg[cmd.del_idx] <= ids_reg[cnt_m1[PEER_W-1:0]];
            end
            ids_reg[cnt_m1[PEER_W-1:0]] <= '0;
            cnt_reg                     <= cnt_m1;
        end
    end

endmodule
`default_nettype wire

// ===== tb/sv/ranging_peer_table_engine_tb.sv =====
// Self-checking testbench for ranging_peer_table_engine: peer list, record ops,
// new round and target selection checked against an in-bench table predictor.
// Depends on rpte_pkg and the engine RTL only.
`default_nettype none
module ranging_peer_table_engine_tb import rpte_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [ID_W-1:0]   first_id;
        logic [ID_W-1:0]   second_id;
        logic [ID_W-1:0]   data_value;
    } request_t;

    typedef struct packed {
        logic [ID_W-1:0]   value;
        logic [STAT_W-1:0] status;
        logic [ACT_W-1:0]  count;
    } reply_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [IN_TDATA_W-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [ID_W-1:0] cfg_data = '0;

    ranging_peer_table_engine uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #5 aclk = ~aclk;

    // predictor state
    logic [ID_W-1:0]   my_id, prio_id;
    int unsigned       n_peers;
    logic [ID_W-1:0]   peers[MAX_PEERS];
    logic [ID_W-1:0]   rec_pid[SLOTS];
    logic [ID_W-1:0]   rec_dist[SLOTS];
    logic [CERT_W-1:0] rec_cert[SLOTS];
    logic [LFSR_W-1:0] tie_reg;

    request_t pending_requests[$];
    reply_t   expected_replies[$];
    int errors = 0;
    int accepted = 0;
    int replies_seen = 0;
    int idle_cycles = 0;
    bit hold_sender = 1'b0;

    function automatic int peer_pos(logic [ID_W-1:0] id);
        for (int i = 0; i < n_peers; i++)
            if (peers[i] == id) return i;
        return -1;
    endfunction

    function automatic int owner_num(logic [ID_W-1:0] id);
        int i;
        if (id == my_id) return 0;
        i = peer_pos(id);
        return i < 0 ? -1 : i + 1;
    endfunction

    function automatic int slot_of(int ow, logic [ID_W-1:0] pid);
        if (pid == 0) return -1;
        for (int j = 0; j < MAX_PEERS; j++)
            if (rec_pid[ow*MAX_PEERS+j] == pid) return ow*MAX_PEERS + j;
        return -1;
    endfunction

    function automatic int claim_slot(int ow, logic [ID_W-1:0] pid);
        int s;
        s = slot_of(ow, pid);
        if (s >= 0) return s;
        if (pid == 0) return -1;
        for (int j = 0; j < MAX_PEERS; j++) begin
            s = ow*MAX_PEERS + j;
            if (rec_pid[s] == 0) begin
                rec_pid[s] = pid;
                rec_dist[s] = DIST_INVALID;
                rec_cert[s] = '0;
                return s;
            end
        end
        return -2;
    endfunction

    function automatic void wipe_row(int ow);
        for (int j = 0; j < MAX_PEERS; j++) begin
            rec_pid[ow*MAX_PEERS+j] = '0;
            rec_dist[ow*MAX_PEERS+j] = '0;
            rec_cert[ow*MAX_PEERS+j] = '0;
        end
    endfunction

    function automatic logic [LFSR_W-1:0] tie_step();
        logic lsb;
        lsb = tie_reg[0];
        tie_reg = tie_reg >> 1;
        if (lsb) tie_reg = tie_reg ^ LFSR_TAPS;
        return tie_reg;
    endfunction

    function automatic logic [ID_W-1:0] pick_target();
        int unsigned lowest, ties;
        logic [ID_W-1:0] target, pid;
        int s;
        lowest = 256; ties = 0; target = '0;
        for (int i = 0; i < n_peers; i++) begin
            pid = peers[i];
            if (pid == my_id) continue;
            if (my_id != prio_id && pid == prio_id) return pid;
            s = slot_of(0, pid);
            if (s < 0) return pid;
            if (rec_cert[s] < lowest) begin
                lowest = rec_cert[s]; target = pid; ties = 1;
            end else if (rec_cert[s] == lowest) begin
                ties++;
                if ((int'(tie_step()) % ties) == 0) target = pid;
            end
        end
        return target;
    endfunction

    function automatic reply_t table_apply(request_t r);
        reply_t o;
        int oa, s, i, last;
        o.value = '0; o.status = ST_IGNORED;
        case (r.func)
            FN_ADD: begin
                if (r.first_id != 0 && peer_pos(r.first_id) < 0) begin
                    if (n_peers >= MAX_PEERS) o.status = ST_FULL;
                    else begin
                        wipe_row(n_peers + 1);
                        peers[n_peers] = r.first_id;
                        n_peers++;
                        o.status = ST_DONE;
                    end
                end
            end
            FN_REMOVE: begin
                i = peer_pos(r.first_id);
                if (i >= 0) begin
                    for (int k = 0; k <= n_peers; k++) begin
                        s = slot_of(k, r.first_id);
                        if (s >= 0) begin
                            rec_dist[s] = DIST_INVALID; rec_cert[s] = '0;
                        end
                    end
                    last = n_peers - 1;
                    peers[i] = peers[last];
                    for (int j = 0; j < MAX_PEERS; j++) begin
                        rec_pid[(i+1)*MAX_PEERS+j] = rec_pid[(last+1)*MAX_PEERS+j];
                        rec_dist[(i+1)*MAX_PEERS+j] = rec_dist[(last+1)*MAX_PEERS+j];
                        rec_cert[(i+1)*MAX_PEERS+j] = rec_cert[(last+1)*MAX_PEERS+j];
                    end
                    peers[last] = '0;
                    wipe_row(last + 1);
                    n_peers--;
                    o.status = ST_DONE;
                end
            end
            FN_SETDIST, FN_GETDIST, FN_SETCERT, FN_BUMP, FN_RESETCERT, FN_GETCERT: begin
                oa = owner_num(r.first_id);
                if (r.func == FN_GETDIST) o.value = DIST_INVALID;
                if (oa >= 0 && owner_num(r.second_id) >= 0) begin
                    if (r.func == FN_SETDIST || r.func == FN_SETCERT || r.func == FN_BUMP) begin
                        s = claim_slot(oa, r.second_id);
                        if (s == -2) o.status = ST_FULL;
                        else if (s >= 0) begin
                            if (r.func == FN_SETDIST) rec_dist[s] = r.data_value;
                            else if (r.func == FN_SETCERT) rec_cert[s] = r.data_value[7:0];
                            else if (rec_cert[s] != CERT_MAX) rec_cert[s]++;
                            o.status = ST_DONE;
                        end
                    end else begin
                        s = slot_of(oa, r.second_id);
                        if (s >= 0) begin
                            if (r.func == FN_GETDIST) begin
                                o.value = rec_dist[s]; o.status = ST_DONE;
                            end else if (r.func == FN_RESETCERT) begin
                                rec_cert[s] = '0; o.status = ST_DONE;
                            end else if (rec_dist[s] != DIST_INVALID) begin
                                o.value = ID_W'(rec_cert[s]); o.status = ST_DONE;
                            end
                        end
                    end
                end
            end
            FN_NEWROUND: begin
                for (int k = 0; k < (n_peers + 1) * MAX_PEERS; k++)
                    if (rec_pid[k] != 0) rec_dist[k] = DIST_INVALID;
                o.status = ST_DONE;
            end
            FN_SELECT: begin
                o.value = pick_target();
                o.status = o.value != 0 ? ST_DONE : ST_IGNORED;
            end
            default: ;
        endcase
        o.count = ACT_W'(n_peers);
        return o;
    endfunction

    function automatic void table_reset();
        my_id = '0; prio_id = PRIO_RESET;
        n_peers = 0;
        for (int i = 0; i < MAX_PEERS; i++) peers[i] = '0;
        for (int k = 0; k < SLOTS; k++) begin
            rec_pid[k] = '0; rec_dist[k] = '0; rec_cert[k] = '0;
        end
        tie_reg = SEED_RESET;
    endfunction

    // requests: field order in tdata is func low, then first, second, data
    function automatic logic [IN_TDATA_W-1:0] pack_req(request_t r);
        return {4'b0, r.data_value, r.second_id, r.first_id, r.func};
    endfunction
    function automatic request_t unpack_req(logic [IN_TDATA_W-1:0] d);
        request_t r;
        r.func = d[3:0]; r.first_id = d[19:4]; r.second_id = d[35:20];
        r.data_value = d[51:36];
        return r;
    endfunction

    // driver
    int send_gap = 0;
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                accepted++;
                expected_replies.push_back(table_apply(unpack_req(s_tdata)));
            end
            if (s_tvalid && !s_tready) begin
                // hold
            end else if (send_gap > 0) begin
                send_gap--;
                s_tvalid <= 1'b0;
            end else if (!hold_sender && pending_requests.size() > 0) begin
                s_tdata <= pack_req(pending_requests.pop_front());
                s_tvalid <= 1'b1;
                send_gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 15);
                if ($urandom_range(0, 2) == 0) send_gap = 0;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // monitor
    int recv_gap = 0;
    always @(posedge aclk) begin
        reply_t got, want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got.value = m_tdata[15:0];
                got.status = m_tdata[17:16];
                got.count = m_tdata[21:18];
                replies_seen++;
                if (expected_replies.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected reply, exp none got %h", $realtime, got);
                end else begin
                    want = expected_replies.pop_front();
                    if (got.value !== want.value) begin
                        errors++;
                        $display("%0t: value exp %h got %h", $realtime, want.value, got.value);
                    end
                    if (got.status !== want.status) begin
                        errors++;
                        $display("%0t: status exp %0d got %0d", $realtime, want.status,
                                 got.status);
                    end
                    if (got.count !== want.count) begin
                        errors++;
                        $display("%0t: count exp %0d got %0d", $realtime, want.count,
                                 got.count);
                    end
                end
                recv_gap = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 15);
            end
            if (recv_gap > 0 && !(m_tvalid && m_tready)) recv_gap--;
            m_tready <= (recv_gap == 0);
        end
    end

    // watchdog
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    logic [ID_W-1:0] id_pool[12];

    function automatic logic [ID_W-1:0] any_id();
        case ($urandom_range(0, 9))
            0: return ID_W'($urandom);
            1: return my_id;
            2: return 16'h0000;
            default: return id_pool[$urandom_range(0, 11)];
        endcase
    endfunction

    function automatic request_t rand_req();
        request_t r;
        int p;
        p = $urandom_range(0, 99);
        if (p < 10) r.func = FN_ADD;
        else if (p < 16) r.func = FN_REMOVE;
        else if (p < 30) r.func = FN_SETDIST;
        else if (p < 40) r.func = FN_GETDIST;
        else if (p < 50) r.func = FN_SETCERT;
        else if (p < 62) r.func = FN_BUMP;
        else if (p < 67) r.func = FN_RESETCERT;
        else if (p < 76) r.func = FN_GETCERT;
        else if (p < 80) r.func = FN_NEWROUND;
        else if (p < 97) r.func = FN_SELECT;
        else r.func = FUNC_W'($urandom_range(10, 15));
        r.first_id = any_id();
        r.second_id = any_id();
        r.data_value = $urandom_range(0, 3) == 0 ? ID_W'($urandom_range(0, 3)) : ID_W'($urandom);
        if (r.func == FN_SETCERT && $urandom_range(0, 1))
            r.data_value[7:0] = CERT_W'($urandom_range(0, 2));
        return r;
    endfunction

    task automatic wait_drain();
        while (pending_requests.size() > 0 || s_tvalid || expected_replies.size() > 0)
            @(posedge aclk);
        repeat (300) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [ID_W-1:0] val);
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1'b1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        if (idx == CFG_OWN_ID) my_id = val;
        else if (idx == CFG_PRIO_ID) prio_id = val;
        else tie_reg = val != 0 ? val : SEED_RESET;
        @(posedge aclk);
    endtask

    function automatic void push(logic [FUNC_W-1:0] f, logic [ID_W-1:0] a,
                                 logic [ID_W-1:0] b, logic [ID_W-1:0] d);
        request_t r;
        r.func = f; r.first_id = a; r.second_id = b; r.data_value = d;
        pending_requests.push_back(r);
    endfunction

    initial begin
        table_reset();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: list full, duplicates, a full record row, saturation, selects
        for (int i = 0; i < 8; i++) push(FN_ADD, ID_W'(16'h0101 + i), 0, 0);
        push(FN_ADD, 16'h0101, 0, 0);
        push(FN_ADD, 16'hFFFF, 0, 0);
        push(FN_ADD, 16'h0000, 0, 0);
        push(FN_SELECT, 0, 0, 0);
        for (int i = 0; i < 8; i++)
            push(FN_SETCERT, 16'h0000, ID_W'(16'h0101 + i), 16'h00FF);
        push(FN_SETDIST, 16'h0000, 16'h0000, 16'hFFFF);
        push(FN_BUMP, 16'h0000, 16'h0101, 0);
        push(FN_GETCERT, 16'h0000, 16'h0101, 0);
        push(FN_SETDIST, 16'h0000, 16'h0102, 16'h0000);
        push(FN_GETCERT, 16'h0000, 16'h0102, 0);
        push(FN_GETDIST, 16'hFFFF, 16'h0101, 0);
        push(FN_RESETCERT, 16'h0101, 16'h0000, 0);
        push(FN_SELECT, 0, 0, 0);
        push(FN_NEWROUND, 0, 0, 0);
        push(FN_REMOVE, 16'h0103, 0, 0);
        push(FN_REMOVE, 16'h0103, 0, 0);
        push(4'hF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        wait_drain();

        write_reg(CFG_SEED, 16'h0000);
        write_reg(CFG_PRIO_ID, 16'h0105);
        write_reg(CFG_OWN_ID, 16'hFFFF);
        for (int ph = 0; ph < 5; ph++) begin
            for (int i = 0; i < 12; i++)
                id_pool[i] = $urandom_range(0, 3) == 0 ? ID_W'($urandom) : ID_W'(16'h0100 + i);
            if (ph == 3) id_pool[0] = 16'hFFFF;
            if (ph == 4) id_pool[1] = prio_id;
            for (int n = 0; n < 270; n++) begin
                pending_requests.push_back(rand_req());
                if (n == 135) begin
                    // sender holds until every reply has arrived
                    while (pending_requests.size() > 0 || s_tvalid) @(posedge aclk);
                    hold_sender = 1'b1;
                    while (expected_replies.size() > 0) @(posedge aclk);
                    hold_sender = 1'b0;
                end
            end
            wait_drain();
            case (ph)
                0: begin write_reg(CFG_OWN_ID, 16'h0000); write_reg(CFG_SEED, 16'hFFFF); end
                1: begin write_reg(CFG_PRIO_ID, 16'h0000); write_reg(CFG_SEED, 16'h0001); end
                2: begin write_reg(CFG_OWN_ID, 16'h0104); write_reg(CFG_PRIO_ID, 16'hFFFF); end
                3: begin write_reg(CFG_PRIO_ID, ID_W'($urandom));
                         write_reg(CFG_SEED, ID_W'($urandom_range(1, 65535))); end
                default: ;
            endcase
        end
        $display("covered %0d requests, %0d replies across config phases", accepted,
                 replies_seen);
        if (errors == 0 && expected_replies.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule
`default_nettype wire

// ===== files.f =====
rtl/rpte_pkg.sv
rtl/rpte_slot_ram.sv
rtl/rpte_peer_list.sv
rtl/ranging_peer_table_engine.sv
tb/sv/ranging_peer_table_engine_tb.sv
